FILE: hw/rtl/cce_pkg.sv
package cce_pkg;

   // Stream payload widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Masked command codes
   localparam logic [7:0] OP_WRITE     = 8'h01;
   localparam logic [7:0] OP_READ      = 8'h02;
   localparam logic [7:0] OP_NOP       = 8'h03;
   localparam logic [7:0] OP_SENSE     = 8'h04;
   localparam logic [7:0] OP_CONTROL   = 8'h07;
   localparam logic [7:0] OP_RESERVED  = 8'h0C;
   localparam logic [7:0] OP_SENSE_CMD = 8'h14;
   localparam logic [7:0] OP_SET_BASIC = 8'h43;
   localparam logic [7:0] OP_WRITE_EOF = 8'h81;
   localparam logic [7:0] OP_SET_EXT   = 8'hC3;
   localparam logic [7:0] OP_PREPARE   = 8'hE3;
   localparam logic [7:0] OP_SENSE_ID  = 8'hE4;

   // Control unit identity and sense codes
   localparam logic [23:0] CU_TYPE      = 24'h308860;
   localparam logic [7:0]  SENSE_REJECT = 8'h80;
   localparam logic [7:0]  ID_LEAD_BYTE = 8'hFF;
   localparam logic [7:0]  ID_LAST_BYTE = 8'h01;
   localparam logic [2:0]  ID_LEN       = 3'd7;

   // Controller to datapath
   typedef struct packed {
      logic execute;   // decode the accepted command
      logic step;      // advance to the next result
   } cce_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_beat; // current result is the final one
   } cce_stat_type;

   // Sense-ID byte at a given position
   function automatic logic [7:0] cce_id_byte(input logic [2:0] idx,
                                              input logic [15:0] dev_type);
      logic [7:0] b;
      case (idx)
         3'd0:    b = ID_LEAD_BYTE;
         3'd1:    b = CU_TYPE[23:16];
         3'd2:    b = CU_TYPE[15:8];
         3'd3:    b = CU_TYPE[7:0];
         3'd4:    b = dev_type[15:8];
         3'd5:    b = dev_type[7:0];
         default: b = ID_LAST_BYTE;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/cce_ctrl.sv
module cce_ctrl
   import cce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output cce_cmd_type  cmd,
   input  cce_stat_type stat
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_xfer;

   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_xfer    = rsp_valid_ff && rsp_tready;
   assign cmd.execute = req_tvalid && req_tready;
   assign cmd.step    = rsp_xfer && !stat.last_beat;

   // Next state: accept in idle, drain results, return after last transfer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.execute) begin
               state_in     = ST_SEND;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SEND: begin
            if (rsp_xfer && stat.last_beat) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/cce_dp.sv
module cce_dp
   import cce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cce_cmd_type  cmd,
   output cce_stat_type stat,
   input  logic [7:0]   command_code,
   input  logic [15:0]  byte_count,
   input  logic         csr_valid,
   input  logic [15:0]  csr_data,
   output logic         unit_check,
   output logic         unit_exception,
   output logic [15:0]  residual_count,
   output logic         more_data,
   output logic         data_valid,
   output logic [7:0]   data_byte,
   output logic         last_result
);

   // Architectural state
   logic        ext_mode_ff, ext_mode_in;
   logic [7:0]  sense_reg_ff, sense_reg_in;
   logic [15:0] dev_type_ff, dev_type_in;

   // Per-command result registers
   logic        uc_ff, uc_in;
   logic        ux_ff, ux_in;
   logic [15:0] resid_ff, resid_in;
   logic        more_ff, more_in;
   logic        has_data_ff, has_data_in;
   logic        is_sense_ff, is_sense_in;
   logic [7:0]  sense_byte_ff, sense_byte_in;
   logic [2:0]  last_idx_ff, last_idx_in;
   logic [2:0]  idx_ff, idx_in;

   logic [7:0]  op;
   logic [2:0]  ndata;
   logic        short_id;

   // Strip modifier bits by the fixed priority chain
   function automatic logic [7:0] mask_code(input logic [7:0] code, input logic ext);
      logic [7:0] m;
      if (code[2:0] == 3'b111)              m = OP_CONTROL;
      else if (code[1:0] == 2'b10)          m = OP_READ;
      else if (code[3:0] == 4'b1100)        m = OP_RESERVED;
      else if (code[1:0] == 2'b01)          m = ext ? (code & 8'h83) : OP_WRITE;
      else if (code[4:0] == 5'b10100)       m = OP_SENSE_CMD;
      else if ((code & 8'h47) == OP_NOP)    m = OP_NOP;
      else if ((code & 8'hC7) == OP_SET_BASIC) m = OP_SET_BASIC;
      else                                  m = code;
      return m;
   endfunction

   assign op       = mask_code(command_code, ext_mode_ff);
   assign short_id = (byte_count < {13'd0, ID_LEN});

   // Decode the command and work out status, state updates and result count
   always_comb begin
      ext_mode_in   = ext_mode_ff;
      sense_reg_in  = sense_reg_ff;
      dev_type_in   = csr_valid ? csr_data : dev_type_ff;
      uc_in         = uc_ff;
      ux_in         = ux_ff;
      resid_in      = resid_ff;
      more_in       = more_ff;
      has_data_in   = has_data_ff;
      is_sense_in   = is_sense_ff;
      sense_byte_in = sense_byte_ff;
      last_idx_in   = last_idx_ff;
      idx_in        = cmd.step ? idx_ff + 3'd1 : idx_ff;
      ndata         = 3'd0;

      if (cmd.execute) begin
         uc_in         = 1'b0;
         ux_in         = 1'b0;
         resid_in      = byte_count;
         more_in       = 1'b0;
         is_sense_in   = 1'b0;
         sense_byte_in = sense_reg_ff;
         idx_in        = 3'd0;
         case (op)
            OP_WRITE: begin
               resid_in = '0;
            end
            OP_WRITE_EOF, OP_CONTROL, OP_NOP, OP_PREPARE, OP_SENSE_CMD: begin
            end
            OP_READ: begin
               ux_in = 1'b1;
            end
            OP_SET_BASIC: begin
               if (!ext_mode_ff) begin
                  sense_reg_in = SENSE_REJECT;
                  uc_in        = 1'b1;
               end else begin
                  ext_mode_in = 1'b0;
                  resid_in    = '0;
               end
            end
            OP_SET_EXT: begin
               ext_mode_in = 1'b1;
               resid_in    = '0;
            end
            OP_SENSE: begin
               if (!ext_mode_ff) begin
                  sense_reg_in = SENSE_REJECT;
                  uc_in        = 1'b1;
               end else begin
                  ndata        = (byte_count != '0) ? 3'd1 : 3'd0;
                  more_in      = (byte_count == '0);
                  is_sense_in  = 1'b1;
                  sense_reg_in = '0;
               end
            end
            OP_SENSE_ID: begin
               ndata   = short_id ? byte_count[2:0] : ID_LEN;
               more_in = short_id;
            end
            default: begin
               sense_reg_in = SENSE_REJECT;
               uc_in        = 1'b1;
            end
         endcase
         if (ndata != 3'd0) begin
            resid_in = byte_count - {13'd0, ndata};
         end
         has_data_in = (ndata != 3'd0);
         last_idx_in = (ndata != 3'd0) ? ndata - 3'd1 : 3'd0;
      end
   end

   // Hold architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_mode_ff  <= 1'b0;
         sense_reg_ff <= '0;
         dev_type_ff  <= '0;
      end else begin
         ext_mode_ff  <= ext_mode_in;
         sense_reg_ff <= sense_reg_in;
         dev_type_ff  <= dev_type_in;
      end
   end

   // Hold result fields of the current command
   always_ff @(posedge clock) begin
      uc_ff         <= uc_in;
      ux_ff         <= ux_in;
      resid_ff      <= resid_in;
      more_ff       <= more_in;
      has_data_ff   <= has_data_in;
      is_sense_ff   <= is_sense_in;
      sense_byte_ff <= sense_byte_in;
      last_idx_ff   <= last_idx_in;
      idx_ff        <= idx_in;
   end

   assign stat.last_beat = (idx_ff == last_idx_ff);

   // Present the current result
   assign unit_check     = uc_ff;
   assign unit_exception = ux_ff;
   assign residual_count = resid_ff;
   assign more_data      = more_ff;
   assign data_valid     = has_data_ff;
   assign last_result    = stat.last_beat;
   assign data_byte      = !has_data_ff ? 8'h00 :
                           is_sense_ff  ? sense_byte_ff :
                                          cce_id_byte(idx_ff, dev_type_ff);

endmodule

FILE: hw/rtl/channel_command_executor.sv
// Channel command executor. One command (code byte and byte count) is taken
// while the block is idle; it is decoded in the cycle of its transfer, and
// its results then leave one per cycle unless the result side stalls. A command
// occupies the block until its last result is taken; the result sequencer steps
// through the identifier bytes of a sense-ID one result at a time. The device type
// register is written through the csr port, which is always ready; write it
// only while no command is in progress.
module channel_command_executor
   import cce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command_code [7:0], byte_count [23:8]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // channel_end [0], device_end [1], unit_check [2], unit_exception [3],
   // residual_count [19:4], more_data [20], data_byte [28:21], zero [31:29]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // data_valid [0]
   output logic                  rsp_tuser,
   // last_result
   output logic                  rsp_tlast,
   // device_type
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   cce_cmd_type  cmd;
   cce_stat_type stat;
   logic         unit_check;
   logic         unit_exception;
   logic [15:0]  residual_count;
   logic         more_data;
   logic [7:0]   data_byte;

   assign csr_ready = 1'b1;

   cce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   cce_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .command_code   (req_tdata[7:0]),
      .byte_count     (req_tdata[23:8]),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .unit_check     (unit_check),
      .unit_exception (unit_exception),
      .residual_count (residual_count),
      .more_data      (more_data),
      .data_valid     (rsp_tuser),
      .data_byte      (data_byte),
      .last_result    (rsp_tlast)
   );

   // Pack the result word; channel end and device end are always set
   assign rsp_tdata = {3'b000, data_byte, more_data, residual_count,
                       unit_exception, unit_check, 1'b1, 1'b1};

endmodule

FILE: hw/rtl/cce_checker.sv
module cce_checker
   import cce_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // Result side comes up empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // No new command is taken while results of the previous one are pending
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("command accepted while results pending");

   // Ending status always present
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == 2'b11)
      else $error("channel end or device end missing");

   // A rejected command returns a single result without data
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tlast && !rsp_tuser)
      else $error("rejected command carried data");

endmodule

bind channel_command_executor cce_checker u_cce_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import cce_pkg::*;

   // One result of a channel command as the block should return it
   typedef struct packed {
      logic        channel_end;
      logic        device_end;
      logic        unit_check;
      logic        unit_exception;
      logic [15:0] residual;
      logic        more_data;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic        last_result;
   } cmd_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [15:0]           csr_data = '0;

   // Shadow of the block's state and its device type register
   logic        ext_mode = 1'b0;
   logic [7:0]  sense_byte = 8'h00;
   logic [15:0] dev_type = 16'h0000;

   cmd_status_type status_due[$];
   int unsigned mismatch_count = 0;
   bit          quiet = 1'b0;

   channel_command_executor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Overall time limit
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic bit idle_now();
      return !quiet && ($urandom_range(0, 99) < 34);
   endfunction

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= !idle_now();
   end

   // Strip the modifier bits, highest priority first
   function automatic logic [7:0] fold_modifiers(logic [7:0] code);
      if (code[2:0] == 3'b111) return OP_CONTROL;
      if (code[1:0] == 2'b10) return OP_READ;
      if (code[3:0] == 4'hC) return OP_RESERVED;
      if (code[1:0] == 2'b01) return ext_mode ? (code & 8'h83) : OP_WRITE;
      if (code[4:0] == 5'h14) return OP_SENSE_CMD;
      if ((code & 8'h47) == OP_NOP) return OP_NOP;
      if ((code & 8'hC7) == OP_SET_BASIC) return OP_SET_BASIC;
      return code;
   endfunction

   // Execute one command on the shadow state and queue its results
   function automatic void run_command(logic [7:0] code, logic [15:0] count);
      logic [7:0]  op;
      logic [7:0]  payload [0:6];
      cmd_status_type r;
      int unsigned ndata;
      int unsigned nres;
      op = fold_modifiers(code);
      r = '0;
      r.channel_end = 1'b1;
      r.device_end = 1'b1;
      r.residual = count;
      ndata = 0;
      payload[0] = ID_LEAD_BYTE;
      payload[1] = CU_TYPE[23:16];
      payload[2] = CU_TYPE[15:8];
      payload[3] = CU_TYPE[7:0];
      payload[4] = dev_type[15:8];
      payload[5] = dev_type[7:0];
      payload[6] = ID_LAST_BYTE;
      case (op)
         OP_WRITE: begin
            r.residual = '0;
         end
         OP_WRITE_EOF, OP_CONTROL, OP_NOP, OP_PREPARE, OP_SENSE_CMD: begin
         end
         OP_READ: begin
            r.unit_exception = 1'b1;
         end
         OP_SET_BASIC: begin
            if (!ext_mode) begin
               sense_byte = SENSE_REJECT;
               r.unit_check = 1'b1;
            end else begin
               ext_mode = 1'b0;
               r.residual = '0;
            end
         end
         OP_SET_EXT: begin
            ext_mode = 1'b1;
            r.residual = '0;
         end
         OP_SENSE: begin
            if (!ext_mode) begin
               sense_byte = SENSE_REJECT;
               r.unit_check = 1'b1;
            end else begin
               ndata = (count != 0) ? 1 : 0;
               r.residual = count - 16'(ndata);
               r.more_data = (count == 0);
               payload[0] = sense_byte;
               sense_byte = 8'h00;
            end
         end
         OP_SENSE_ID: begin
            ndata = (count < 16'(ID_LEN)) ? 32'(count) : 32'(ID_LEN);
            r.residual = count - 16'(ndata);
            r.more_data = (count < 16'(ID_LEN));
         end
         default: begin
            sense_byte = SENSE_REJECT;
            r.unit_check = 1'b1;
         end
      endcase
      nres = (ndata != 0) ? ndata : 1;
      for (int unsigned i = 0; i < nres; i++) begin
         r.data_valid = (ndata != 0);
         r.data_byte = (ndata != 0) ? payload[i] : 8'h00;
         r.last_result = (i + 1 == nres);
         status_due.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each result transfer with the oldest expected one
   always @(posedge clock) begin
      cmd_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h user %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = status_due.pop_front();
            check_field("channel_end", 16'(want.channel_end), 16'(rsp_tdata[0]));
            check_field("device_end", 16'(want.device_end), 16'(rsp_tdata[1]));
            check_field("unit_check", 16'(want.unit_check), 16'(rsp_tdata[2]));
            check_field("unit_exception", 16'(want.unit_exception), 16'(rsp_tdata[3]));
            check_field("residual_count", want.residual, rsp_tdata[19:4]);
            check_field("more_data", 16'(want.more_data), 16'(rsp_tdata[20]));
            check_field("data_valid", 16'(want.data_valid), 16'(rsp_tuser));
            check_field("data_byte", 16'(want.data_byte), 16'(rsp_tdata[28:21]));
            check_field("last_result", 16'(want.last_result), 16'(rsp_tlast));
         end
      end
   end

   // Present one command, keep tvalid high until the transfer
   task automatic send_command(input logic [7:0] code, input logic [15:0] count);
      if (idle_now()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
      req_tvalid <= 1'b1;
      req_tdata <= {count, code};
      do @(posedge clock); while (!req_tready);
      run_command(code, count);
   endtask

   // Hold the command side until every result is back, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_device_type(input logic [15:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      dev_type = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_code();
      logic [7:0] r;
      int unsigned sel;
      r = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 12) return r;
      if (sel < 22) return {r[7:2], 2'b01};
      if (sel < 28) return {r[7:2], 2'b10};
      if (sel < 33) return {r[7:3], 3'b111};
      if (sel < 37) return {r[7:4], 4'hC};
      if (sel < 41) return {r[7:5], 5'h14};
      if (sel < 45) return {r[7], 1'b0, r[5:3], 3'b011};
      if (sel < 55) return {2'b01, r[5:3], 3'b011};
      if (sel < 65) return OP_SET_EXT;
      if (sel < 69) return OP_PREPARE;
      if (sel < 84) return OP_SENSE;
      return OP_SENSE_ID;
   endfunction

   function automatic logic [15:0] pick_count();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return 16'($urandom_range(0, 8));
      if (sel < 50) return 16'hFFFF;
      if (sel < 55) return 16'h0000;
      return 16'($urandom);
   endfunction

   // Every opcode, the count extremes and both modes
   task automatic test_directed_codes();
      send_command(OP_WRITE, 16'hFFFF);
      send_command(OP_READ, 16'h0000);
      send_command(OP_CONTROL, 16'h1234);
      send_command(OP_NOP, 16'h0001);
      send_command(OP_RESERVED, 16'h0005);
      send_command(OP_SENSE_CMD, 16'hFFFF);
      send_command(OP_SENSE, 16'h0001);      // rejected in basic mode
      send_command(OP_SET_BASIC, 16'h0002);  // rejected in basic mode
      send_command(OP_SENSE_ID, 16'h0000);
      send_command(OP_SENSE_ID, 16'h0003);
      send_command(OP_SENSE_ID, 16'h0007);
      send_command(OP_SENSE_ID, 16'hFFFF);
      send_command(8'h00, 16'hFFFF);
      send_command(OP_PREPARE, 16'h0009);
      send_command(8'hFF, 16'h0000);
      send_command(OP_WRITE_EOF, 16'h0002);  // plain write in basic mode
      send_command(OP_SET_EXT, 16'hFFFF);
      send_command(OP_SENSE, 16'hFFFF);      // returns the reject code
      send_command(OP_SENSE, 16'h0001);      // sense byte now clear
      send_command(OP_WRITE_EOF, 16'h0004);
      send_command(8'h85, 16'h0000);
      send_command(8'h05, 16'h0003);
      send_command(8'h08, 16'h0001);
      send_command(OP_SENSE, 16'h0000);      // clears without returning data
      send_command(OP_SET_BASIC, 16'h0007);
   endtask

   // Identifier bytes across device type settings
   task automatic test_device_type_sweep();
      write_device_type(16'hFFFF);
      send_command(OP_SENSE_ID, 16'h0007);
      send_command(OP_SENSE_ID, 16'h0006);
      write_device_type(16'h0000);
      send_command(OP_SENSE_ID, 16'h0007);
      write_device_type(16'hA55A);
      send_command(OP_SENSE_ID, 16'hFFFF);
      write_device_type(16'($urandom));
      send_command(OP_SENSE_ID, 16'h0005);
   endtask

   task automatic test_random_commands();
      for (int phase = 0; phase < 3; phase++) begin
         write_device_type(16'($urandom));
         for (int n = 0; n < 120; n++) send_command(pick_code(), pick_count());
      end
   endtask

   // No idling on either side
   task automatic test_back_to_back();
      settle();
      quiet = 1'b1;
      for (int n = 0; n < 60; n++) send_command(pick_code(), pick_count());
      settle();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_codes();
      test_device_type_sweep();
      test_random_commands();
      test_back_to_back();
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && status_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/cce_pkg.sv
hw/rtl/cce_ctrl.sv
hw/rtl/cce_dp.sv
hw/rtl/channel_command_executor.sv
hw/rtl/cce_checker.sv
verif/tb_top.sv
